### hdl/bpl_pkg.sv
// shared types, register indexes and widths for the balance point learner
`timescale 1ns / 1ps

package bpl_pkg;

    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 16;
    localparam int LIMIT_W  = 16;
    localparam int ALPHA_W  = 17;
    localparam int FINE_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE_MS      = 3'd0,
        REG_STABLE_MS      = 3'd1,
        REG_MIN_WRITE_MS   = 3'd2,
        REG_MAX_ANGLE_ERR  = 3'd3,
        REG_MAX_RATE       = 3'd4,
        REG_MAX_MOTOR_CMD  = 3'd5,
        REG_ALPHA          = 3'd6
    } bpl_reg_idx_t;

    // request kinds
    localparam logic CMD_UPDATE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  settle_ms;
        logic [TIME_W-1:0]  stable_ms;
        logic [TIME_W-1:0]  min_write_interval_ms;
        logic [LIMIT_W-1:0] max_angle_error;
        logic [LIMIT_W-1:0] max_rate;
        logic [LIMIT_W-1:0] max_motor_command;
        logic [ALPHA_W-1:0] smoothing_alpha;
    } bpl_cfg_t;

    typedef struct packed {
        logic                      cmd;
        logic [TIME_W-1:0]         now_ms;
        logic signed [ANGLE_W-1:0] tilt_angle;
        logic signed [ANGLE_W-1:0] tilt_rate;
        logic                      gyro_fresh;
        logic signed [ANGLE_W-1:0] active_point;
        logic signed [ANGLE_W-1:0] motor_command;
        logic signed [ANGLE_W-1:0] restart_point;
    } bpl_item_t;

    typedef struct packed {
        logic                      save_now;
        logic signed [ANGLE_W-1:0] learned_point;
    } bpl_result_t;

endpackage

### hdl/bpl_cfg_regs.sv
// configuration register file of the balance point learner
`timescale 1ns / 1ps

module bpl_cfg_regs
    import bpl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output bpl_cfg_t             cfg
);

    bpl_cfg_t cfg_reg;
    bpl_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    // register decode, unknown indexes leave everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (bpl_reg_idx_t'(cfg_index))
                REG_SETTLE_MS:     cfg_next.settle_ms = cfg_data[TIME_W-1:0];
                REG_STABLE_MS:     cfg_next.stable_ms = cfg_data[TIME_W-1:0];
                REG_MIN_WRITE_MS:  cfg_next.min_write_interval_ms = cfg_data[TIME_W-1:0];
                REG_MAX_ANGLE_ERR: cfg_next.max_angle_error = cfg_data[LIMIT_W-1:0];
                REG_MAX_RATE:      cfg_next.max_rate = cfg_data[LIMIT_W-1:0];
                REG_MAX_MOTOR_CMD: cfg_next.max_motor_command = cfg_data[LIMIT_W-1:0];
                REG_ALPHA:         cfg_next.smoothing_alpha = cfg_data[ALPHA_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/bpl_core.sv
// learning state and the combinational update of one request
`timescale 1ns / 1ps

module bpl_core
    import bpl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bpl_cfg_t    cfg,
    input  logic        step,
    input  bpl_item_t   item,
    output bpl_result_t result
);

    localparam int DIFF_W = FINE_W + 1;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;

    logic signed [FINE_W-1:0] fine_reg, fine_next;
    logic [TIME_W-1:0]        restart_time_reg, restart_time_next;
    logic [TIME_W-1:0]        stable_start_reg, stable_start_next;
    logic [TIME_W-1:0]        last_save_reg, last_save_next;
    logic                     stable_started_reg, stable_started_next;
    logic                     saved_once_reg, saved_once_next;

    logic [TIME_W-1:0]         since_restart, since_stable, since_save;
    logic signed [ANGLE_W:0]   angle_err, rate_ext, motor_ext;
    logic [ANGLE_W:0]          angle_mag, rate_mag, motor_mag;
    logic                      stable;
    logic [ALPHA_W-1:0]        alpha_sat;
    logic signed [DIFF_W-1:0]  target, diff;
    logic signed [PROD_W-1:0]  prod, prod_rnd;
    logic signed [FINE_W-1:0]  fine_upd;
    logic signed [FINE_W:0]    learned_sum;

    // wrapped time differences
    assign since_restart = item.now_ms - restart_time_reg;
    assign since_stable  = item.now_ms - stable_start_reg;
    assign since_save    = item.now_ms - last_save_reg;

    // stability window
    assign angle_err = {item.tilt_angle[ANGLE_W-1], item.tilt_angle}
                     - {item.active_point[ANGLE_W-1], item.active_point};
    assign rate_ext  = {item.tilt_rate[ANGLE_W-1], item.tilt_rate};
    assign motor_ext = {item.motor_command[ANGLE_W-1], item.motor_command};
    assign angle_mag = angle_err[ANGLE_W] ? (ANGLE_W+1)'(0) - angle_err : angle_err;
    assign rate_mag  = rate_ext[ANGLE_W]  ? (ANGLE_W+1)'(0) - rate_ext  : rate_ext;
    assign motor_mag = motor_ext[ANGLE_W] ? (ANGLE_W+1)'(0) - motor_ext : motor_ext;
    assign stable = item.gyro_fresh
                 && (angle_mag <= {1'b0, cfg.max_angle_error})
                 && (rate_mag  <= {1'b0, cfg.max_rate})
                 && (motor_mag <= {1'b0, cfg.max_motor_command});

    // smoothing step: fine += floor((alpha * (target - fine) + half) / 2^16)
    assign alpha_sat = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
    assign target    = {item.active_point[ANGLE_W-1], item.active_point, {FRAC_W{1'b0}}};
    assign diff      = target - {fine_reg[FINE_W-1], fine_reg};
    assign prod      = $signed({1'b0, alpha_sat}) * diff;
    assign prod_rnd  = prod + PROD_W'(32768);
    assign fine_upd  = fine_reg + FINE_W'(prod_rnd >>> FRAC_W);

    // round the new point to whole units, half up
    assign learned_sum = {fine_upd[FINE_W-1], fine_upd} + (FINE_W+1)'(32768);

    always_comb begin
        fine_next           = fine_reg;
        restart_time_next   = restart_time_reg;
        stable_start_next   = stable_start_reg;
        last_save_next      = last_save_reg;
        stable_started_next = stable_started_reg;
        saved_once_next     = saved_once_reg;
        result              = '0;
        if (step) begin
            if (item.cmd == CMD_RESTART) begin
                fine_next           = {item.restart_point, {FRAC_W{1'b0}}};
                restart_time_next   = item.now_ms;
                stable_start_next   = '0;
                last_save_next      = '0;
                stable_started_next = 1'b0;
                saved_once_next     = 1'b0;
            end else if (since_restart < cfg.settle_ms || !stable) begin
                stable_started_next = 1'b0;
            end else if (!stable_started_reg) begin
                stable_start_next   = item.now_ms;
                stable_started_next = 1'b1;
            end else if (since_stable >= cfg.stable_ms
                         && !(saved_once_reg && since_save < cfg.min_write_interval_ms)) begin
                fine_next              = fine_upd;
                last_save_next         = item.now_ms;
                saved_once_next        = 1'b1;
                result.save_now        = 1'b1;
                result.learned_point   = learned_sum[FINE_W-1:FRAC_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fine_reg           <= '0;
            restart_time_reg   <= '0;
            stable_start_reg   <= '0;
            last_save_reg      <= '0;
            stable_started_reg <= 1'b0;
            saved_once_reg     <= 1'b0;
        end else begin
            fine_reg           <= fine_next;
            restart_time_reg   <= restart_time_next;
            stable_start_reg   <= stable_start_next;
            last_save_reg      <= last_save_next;
            stable_started_reg <= stable_started_next;
            saved_once_reg     <= saved_once_next;
        end
    end

endmodule

### hdl/balance_point_learner.sv
// top level: request register, learning core and result register
`timescale 1ns / 1ps

// Balance point learner. Each request is taken into an input register, worked
// on by the learning core (stability checks, one 18 x 33 bit multiply for the
// smoothing step) and its result lands in an output register. One request is
// accepted every cycle while the result side is not stalled. The learning
// state is updated in the same cycle that a request is worked on, so the next
// request always sees it. Configuration writes are accepted in every cycle and
// take effect from the next one; write them only while no request is pending.

module balance_point_learner
    import bpl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data,
    // requests
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [TIME_W-1:0]          s_now_ms,
    input  logic signed [ANGLE_W-1:0]  s_tilt_angle,
    input  logic signed [ANGLE_W-1:0]  s_tilt_rate,
    input  logic                       s_gyro_fresh,
    input  logic signed [ANGLE_W-1:0]  s_active_point,
    input  logic signed [ANGLE_W-1:0]  s_motor_command,
    input  logic signed [ANGLE_W-1:0]  s_restart_point,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_save_now,
    output logic signed [ANGLE_W-1:0]  m_learned_point
);

    bpl_cfg_t    cfg;
    bpl_item_t   item_reg;
    logic        item_vld_reg;
    bpl_result_t core_res;
    bpl_result_t res_reg;
    logic        res_vld_reg;
    logic        advance;

    bpl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // request moves on when the result register is free or being emptied
    assign advance = item_vld_reg && (!res_vld_reg || m_ready);
    assign s_ready = !item_vld_reg || advance;

    bpl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .item    (item_reg),
        .result  (core_res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
        end else if (s_ready) begin
            item_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.cmd           <= s_cmd;
            item_reg.now_ms        <= s_now_ms;
            item_reg.tilt_angle    <= s_tilt_angle;
            item_reg.tilt_rate     <= s_tilt_rate;
            item_reg.gyro_fresh    <= s_gyro_fresh;
            item_reg.active_point  <= s_active_point;
            item_reg.motor_command <= s_motor_command;
            item_reg.restart_point <= s_restart_point;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (advance) begin
            res_vld_reg <= 1'b1;
        end else if (m_ready) begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= core_res;
        end
    end

    assign m_valid         = res_vld_reg;
    assign m_save_now      = res_reg.save_now;
    assign m_learned_point = res_reg.learned_point;

endmodule

### hdl/bpl_checker.sv
// port-level checks for the balance point learner, bound to the top level
`timescale 1ns / 1ps

module bpl_checker
    import bpl_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_save_now,
    input logic signed [ANGLE_W-1:0] m_learned_point
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    // requests taken but not yet answered
    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            inflight_next = inflight_reg + 2'd1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_save_now) && $stable(m_learned_point))
        else $error("result changed while stalled");

    // no point is reported without a save
    a_point_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_save_now |-> m_learned_point == '0)
        else $error("learned point set without save");

    // back-pressure only when both stages are full
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && inflight_reg == 2'd2)
        else $error("request refused while there is room");

    // never more than two pending, and a result only for a pending request
    a_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg != 2'd3 && (!m_valid || inflight_reg != 2'd0))
        else $error("request and result counts disagree");

endmodule

bind balance_point_learner bpl_checker u_bpl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_save_now      (m_save_now),
    .m_learned_point (m_learned_point)
);
